// ===== rtl/point_rigid_transform_filter_core_macros.svh =====
// Assertion macros shared by the RTL of the point transform filter.
// Both macros expect a clock named clk in scope; PRT_ASSERT also expects an active-low reset named rst_n.
`ifndef POINT_RIGID_TRANSFORM_FILTER_CORE_MACROS_SVH
`define POINT_RIGID_TRANSFORM_FILTER_CORE_MACROS_SVH

// Checked on every rising edge outside of reset.
`define PRT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define PRT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/prt_pkg.sv =====
// Shared widths, register codes, reset values and helpers of the point transform filter.
// No dependencies; every other file of the block but the assertion macros header imports this package.
package prt_pkg;

  localparam int COORD_W    = 16;
  localparam int COLOR_W    = 8;
  localparam int COEF_W     = 16;
  localparam int FRAC_W     = 14;
  localparam int OFF_W      = 20;
  localparam int PROD_W     = 2 * COEF_W;
  localparam int ACC_W      = 35;
  localparam int ROW_W      = 3 * COEF_W;
  localparam int TRANS_W    = 3 * OFF_W;
  localparam int NUM_AXES   = 3;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 6;
  localparam int REG_IDX_W  = 3;

  // Register indexes, at byte address 8 * index.
  localparam logic [REG_IDX_W-1:0] REG_USE_TRANSFORM = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_ROT_ROW_X     = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_ROT_ROW_Y     = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_ROT_ROW_Z     = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_TRANSLATION   = 3'd4;

  // Identity rotation: 1.0 in Q2.14 on the diagonal, row x in the low slot.
  localparam logic [COEF_W-1:0] COEF_ONE = 16'h4000;
  localparam logic [NUM_AXES-1:0][ROW_W-1:0] ROT_RESET = {
    {COEF_ONE, {COEF_W{1'b0}}, {COEF_W{1'b0}}},
    {{COEF_W{1'b0}}, COEF_ONE, {COEF_W{1'b0}}},
    {{COEF_W{1'b0}}, {COEF_W{1'b0}}, COEF_ONE}
  };

  // Load enables for the two register stages inside a row unit.
  typedef struct packed {
    logic ld_prod;
    logic ld_sum;
  } prt_row_ctl_t;

  // Divide by 2^FRAC_W with truncation toward zero, keep the low coordinate bits.
  function automatic logic [COORD_W-1:0] prt_trunc(input logic signed [ACC_W-1:0] acc);
    logic [ACC_W-1:0] biased;
    biased = acc + (acc[ACC_W-1] ? ACC_W'((1 << FRAC_W) - 1) : ACC_W'(0));
    return biased[FRAC_W +: COORD_W];
  endfunction

endpackage

// ===== rtl/prt_in_if.sv =====
// Input channel of the point transform filter: one colored depth pixel per item.
// Depends on prt_pkg for field widths.
interface prt_in_if;
  import prt_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] px;
  logic signed [COORD_W-1:0] py;
  logic signed [COORD_W-1:0] pz;
  logic [COLOR_W-1:0]        blue;
  logic [COLOR_W-1:0]        green;
  logic [COLOR_W-1:0]        red;
  logic [COLOR_W-1:0]        alpha;

  modport source (output valid, px, py, pz, blue, green, red, alpha, input ready);
  modport sink   (input valid, px, py, pz, blue, green, red, alpha, output ready);
endinterface

// ===== rtl/prt_out_if.sv =====
// Result channel of the point transform filter: one transformed, colored point per item.
// Depends on prt_pkg for field widths.
interface prt_out_if;
  import prt_pkg::*;

  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] qx;
  logic [COORD_W-1:0] qy;
  logic [COORD_W-1:0] qz;
  logic [COLOR_W-1:0] out_blue;
  logic [COLOR_W-1:0] out_green;
  logic [COLOR_W-1:0] out_red;

  modport source (output valid, qx, qy, qz, out_blue, out_green, out_red, input ready);
  modport sink   (input valid, qx, qy, qz, out_blue, out_green, out_red, output ready);
endinterface

// ===== rtl/prt_row_mac.sv =====
// One output coordinate: three Q2.14 products in one stage, their sum with the offset in the next.
// Depends on prt_pkg; stage advance comes from the top level as a prt_row_ctl_t.
module prt_row_mac (
  input  logic                              clk,
  input  prt_pkg::prt_row_ctl_t             ctl,
  input  logic [prt_pkg::ROW_W-1:0]         row_coef,
  input  logic signed [prt_pkg::OFF_W-1:0]  offset,
  input  logic signed [prt_pkg::COORD_W-1:0] x,
  input  logic signed [prt_pkg::COORD_W-1:0] y,
  input  logic signed [prt_pkg::COORD_W-1:0] z,
  output logic signed [prt_pkg::ACC_W-1:0]  acc
);
  import prt_pkg::*;

  logic signed [COEF_W-1:0] c0, c1, c2;
  logic signed [PROD_W-1:0] prod_nxt [NUM_AXES];
  logic signed [PROD_W-1:0] prod_r   [NUM_AXES];
  logic signed [OFF_W-1:0]  off_r;
  logic signed [ACC_W-1:0]  acc_nxt;
  logic signed [ACC_W-1:0]  acc_r;

  assign c0 = row_coef[0*COEF_W +: COEF_W];
  assign c1 = row_coef[1*COEF_W +: COEF_W];
  assign c2 = row_coef[2*COEF_W +: COEF_W];

  always_comb begin
    prod_nxt[0] = c0 * x;
    prod_nxt[1] = c1 * y;
    prod_nxt[2] = c2 * z;
  end

  // The offset is whole millimetres, so it enters the sum shifted up by the fraction width.
  assign acc_nxt = ACC_W'(prod_r[0]) + ACC_W'(prod_r[1]) + ACC_W'(prod_r[2])
                 + {{(ACC_W-OFF_W-FRAC_W){off_r[OFF_W-1]}}, off_r, {FRAC_W{1'b0}}};

  always_ff @(posedge clk) begin
    if (ctl.ld_prod) begin
      prod_r <= prod_nxt;
      off_r  <= offset;
    end
    if (ctl.ld_sum) begin
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_r;
endmodule

// ===== rtl/point_rigid_transform_filter_core.sv =====
// Point rigid transform filter: takes one colored depth pixel per item and, with the transform
// mode on, rotates the point by a Q2.14 3x3 matrix and adds a millimetre translation; each
// coordinate is truncated toward zero and wrapped to 16 bits. With the mode off the point passes
// unchanged. Pixels whose resulting z is zero, or whose four color bytes are all zero, produce no
// result. The block accepts one item every clock cycle unless a stalled output has filled the
// pipeline. An item passes in order through the input register, the nine 16x16 multipliers,
// the three-way sum with offset, and the truncation, filtering and output register, one stage
// each. Each stage moves only when the one after it has room, so a stalled output backs up the
// pipeline without losing or repeating an item, and bubbles are squeezed out. Configuration is
// an APB-style port with 64-bit data; register i sits at byte address 8*i and should be written
// only while no item is in flight.
`include "point_rigid_transform_filter_core_macros.svh"

module point_rigid_transform_filter_core (
  input  logic                            clk,
  input  logic                            rst_n,
  prt_in_if.sink                          in_ch,
  prt_out_if.source                       out_ch,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [prt_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [prt_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [prt_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import prt_pkg::*;

  // ---------------------------------------------------------------------------------------------
  // Configuration registers. The register index is the address divided by eight; low address
  // bits are ignored and indexes past the last register are neither written nor read back.
  // ---------------------------------------------------------------------------------------------
  logic                              use_transform_r;
  logic [NUM_AXES-1:0][ROW_W-1:0]    rot_r;
  logic [TRANS_W-1:0]                translation_r;
  logic [REG_IDX_W-1:0]              reg_idx;
  logic                              cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[CFG_ADDR_W-1 -: REG_IDX_W];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      use_transform_r <= 1'b0;
      rot_r           <= ROT_RESET;
      translation_r   <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_USE_TRANSFORM: use_transform_r <= pwdata[0];
        REG_ROT_ROW_X:     rot_r[0]        <= pwdata[ROW_W-1:0];
        REG_ROT_ROW_Y:     rot_r[1]        <= pwdata[ROW_W-1:0];
        REG_ROT_ROW_Z:     rot_r[2]        <= pwdata[ROW_W-1:0];
        REG_TRANSLATION:   translation_r   <= pwdata[TRANS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_USE_TRANSFORM: prdata = CFG_DATA_W'(use_transform_r);
      REG_ROT_ROW_X:     prdata = CFG_DATA_W'(rot_r[0]);
      REG_ROT_ROW_Y:     prdata = CFG_DATA_W'(rot_r[1]);
      REG_ROT_ROW_Z:     prdata = CFG_DATA_W'(rot_r[2]);
      REG_TRANSLATION:   prdata = CFG_DATA_W'(translation_r);
      default:           prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------------------------
  // Pipeline flow control. A stage may load when it is empty or its item moves on in the same
  // cycle. The ready chain runs from the output register back to the input.
  // ---------------------------------------------------------------------------------------------
  logic v1_r, v2_r, v3_r, out_valid_r;
  logic rdy1, rdy2, rdy3, rdy_out;
  logic in_acc;

  assign rdy_out     = !out_valid_r || out_ch.ready;
  assign rdy3        = !v3_r || rdy_out;
  assign rdy2        = !v2_r || rdy3;
  assign rdy1        = !v1_r || rdy2;
  assign in_ch.ready = rdy1;
  assign in_acc      = in_ch.valid && rdy1;

  // Stage 1: input register.
  logic signed [COORD_W-1:0]   x1_r, y1_r, z1_r;
  logic [3:0][COLOR_W-1:0]     col1_r;

  // Stages 2 and 3: the point and color travel beside the row units for the pass-through case
  // and for the final filter.
  logic [COORD_W-1:0]          x2_r, y2_r, z2_r, x3_r, y3_r, z3_r;
  logic [3:0][COLOR_W-1:0]     col2_r, col3_r;

  prt_row_ctl_t                row_ctl;
  logic signed [ACC_W-1:0]     acc [NUM_AXES];

  assign row_ctl.ld_prod = rdy2 && v1_r;
  assign row_ctl.ld_sum  = rdy3 && v2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_ch.valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      x1_r   <= in_ch.px;
      y1_r   <= in_ch.py;
      z1_r   <= in_ch.pz;
      col1_r <= {in_ch.alpha, in_ch.red, in_ch.green, in_ch.blue};
    end
    if (row_ctl.ld_prod) begin
      x2_r   <= x1_r;
      y2_r   <= y1_r;
      z2_r   <= z1_r;
      col2_r <= col1_r;
    end
    if (row_ctl.ld_sum) begin
      x3_r   <= x2_r;
      y3_r   <= y2_r;
      z3_r   <= z2_r;
      col3_r <= col2_r;
    end
  end

  // One multiply-accumulate unit per output coordinate; translation x sits in the low bits.
  for (genvar a = 0; a < NUM_AXES; a++) begin : g_row
    prt_row_mac u_row (
      .clk      (clk),
      .ctl      (row_ctl),
      .row_coef (rot_r[a]),
      .offset   (translation_r[a*OFF_W +: OFF_W]),
      .x        (x1_r),
      .y        (y1_r),
      .z        (z1_r),
      .acc      (acc[a])
    );
  end

  // ---------------------------------------------------------------------------------------------
  // Stage 4: truncate toward zero, pick transformed or raw point, drop empty pixels, and load
  // the output register. A dropped item leaves the output data untouched and clears the valid.
  // ---------------------------------------------------------------------------------------------
  logic [COORD_W-1:0] qx_nxt, qy_nxt, qz_nxt;
  logic               keep;

  always_comb begin
    if (use_transform_r) begin
      qx_nxt = prt_trunc(acc[0]);
      qy_nxt = prt_trunc(acc[1]);
      qz_nxt = prt_trunc(acc[2]);
    end else begin
      qx_nxt = x3_r;
      qy_nxt = y3_r;
      qz_nxt = z3_r;
    end
    keep = (qz_nxt != '0) && (col3_r != '0);
  end

  logic [COORD_W-1:0]      qx_r, qy_r, qz_r;
  logic [2:0][COLOR_W-1:0] col_out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rdy_out) begin
      out_valid_r <= v3_r && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_out && v3_r && keep) begin
      qx_r      <= qx_nxt;
      qy_r      <= qy_nxt;
      qz_r      <= qz_nxt;
      col_out_r <= col3_r[2:0];
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.qx        = qx_r;
  assign out_ch.qy        = qy_r;
  assign out_ch.qz        = qz_r;
  assign out_ch.out_blue  = col_out_r[0];
  assign out_ch.out_green = col_out_r[1];
  assign out_ch.out_red   = col_out_r[2];

  // ---------------------------------------------------------------------------------------------
  // Checks.
  // ---------------------------------------------------------------------------------------------
  `PRT_ASSERT(a_no_zero_depth, out_valid_r |-> (qz_r != '0), "result with zero depth")
  `PRT_ASSERT(a_kept_item_lands, (v3_r && rdy_out && keep) |=> out_valid_r,
              "kept item did not reach the output register")
  `PRT_ASSERT_ALWAYS(a_stall_means_full, (rst_n && !rdy1) |-> (v1_r && v2_r && v3_r && out_valid_r),
                     "input stalled while the pipeline has a free stage")
endmodule

// ===== test/point_rigid_transform_filter_core_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for point_rigid_transform_filter_core: drives pixels, predicts points.
// Depends on prt_pkg, prt_in_if, prt_out_if and the core itself; reads no files.

module point_rigid_transform_filter_core_test;
  import prt_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int RESET_CYCLES = 12;
  // Roughly 900 items with their idle gaps, plus the long hold-off, the register traffic
  // and the drain pauses, taken several times over.
  localparam int CYCLE_LIMIT  = 400000;
  // The pipeline is four stages deep; a dropped pixel can still be in flight after the
  // last expected point has come out, so every drain waits a little longer than that.
  localparam int DRAIN_CYCLES = 12;
  localparam int MAX_IDLE     = 6;
  localparam int HOLD_CYCLES  = 200;
  localparam int MAX_PRINTED  = 40;
  localparam int PHASE_ITEMS  = 115;
  localparam int NUM_PHASES   = 7;
  localparam logic [REG_IDX_W-1:0] REG_LAST = REG_TRANSLATION;

  // Kinds of register setting used by the random phases.
  typedef enum int {CFG_MAX_COEF, CFG_MIN_COEF, CFG_BYPASS, CFG_RANDOM} cfg_kind_t;

  typedef struct {
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic signed [COORD_W-1:0] pz;
    logic [COLOR_W-1:0]        blue;
    logic [COLOR_W-1:0]        green;
    logic [COLOR_W-1:0]        red;
    logic [COLOR_W-1:0]        alpha;
  } pixel_t;

  typedef struct {
    logic [COORD_W-1:0] qx;
    logic [COORD_W-1:0] qy;
    logic [COORD_W-1:0] qz;
    logic [COLOR_W-1:0] blue;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] red;
  } point_t;

  logic                  clk;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  prt_in_if  in_ch ();
  prt_out_if out_ch ();

  point_rigid_transform_filter_core uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Our own copy of the register file, kept in step with every write we issue.
  logic                 xform_on;
  logic [ROW_W-1:0]     rot_rows [NUM_AXES];
  logic [TRANS_W-1:0]   offsets;

  // Points the block still owes us, oldest first.
  point_t expected_points [$];

  int items_sent;
  int points_checked;
  int pixels_dropped;
  int config_writes;
  int input_stall_cycles;
  int fail_count;
  int printed;
  int cycle_count;

  // Idling knobs: each side draws a wait from 0 up to its maximum for every item.
  int send_idle_max;
  int recv_idle_max;
  int stall_left;
  int hold_left;

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Hard stop in case the block wedges and stops moving items.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d points outstanding.", cycle_count,
               expected_points.size());
      $display("Verification failed");
      $finish;
    end
  end

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    fail_count++;
    if (printed < MAX_PRINTED) begin
      $display("[%0t] MISMATCH %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
      printed++;
    end
  endtask

  // One output coordinate: a rotation row applied to the point plus an offset, worked out
  // exactly in 64 bits. Division of a signed longint truncates toward zero, as required.
  function automatic logic [COORD_W-1:0] transform_axis(logic [ROW_W-1:0] row,
                                                        logic [OFF_W-1:0] off, pixel_t p);
    longint scale;
    longint acc;
    scale = longint'(1) <<< FRAC_W;
    acc = longint'($signed(row[0 +: COEF_W]))        * longint'(p.px)
        + longint'($signed(row[COEF_W +: COEF_W]))   * longint'(p.py)
        + longint'($signed(row[2*COEF_W +: COEF_W])) * longint'(p.pz)
        + longint'($signed(off)) * scale;
    return COORD_W'(acc / scale);
  endfunction

  // Works out the point a pixel should give; returns 0 when the pixel is filtered out.
  function automatic bit predict_point(pixel_t p, output point_t q);
    q.blue  = p.blue;
    q.green = p.green;
    q.red   = p.red;
    if (xform_on) begin
      q.qx = transform_axis(rot_rows[0], offsets[0 +: OFF_W], p);
      q.qy = transform_axis(rot_rows[1], offsets[OFF_W +: OFF_W], p);
      q.qz = transform_axis(rot_rows[2], offsets[2*OFF_W +: OFF_W], p);
    end else begin
      q.qx = p.px;
      q.qy = p.py;
      q.qz = p.pz;
    end
    // Zero depth and a fully blank color both suppress the point.
    return (q.qz != '0) && ({p.blue, p.green, p.red, p.alpha} != '0);
  endfunction

  // Appends a prediction behind every point already owed.
  function automatic void owe_point(point_t q);
    expected_points.insert(expected_points.size(), q);
  endfunction

  // Register write as the block should see it: extra high bits are cut off, and writes
  // to indexes past the last register change nothing.
  function automatic void model_config(logic [REG_IDX_W-1:0] idx, logic [63:0] value);
    case (idx)
      REG_USE_TRANSFORM: xform_on = value[0];
      REG_ROT_ROW_X:     rot_rows[0] = value[ROW_W-1:0];
      REG_ROT_ROW_Y:     rot_rows[1] = value[ROW_W-1:0];
      REG_ROT_ROW_Z:     rot_rows[2] = value[ROW_W-1:0];
      REG_TRANSLATION:   offsets = value[TRANS_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic logic [63:0] reg_value(logic [REG_IDX_W-1:0] idx);
    case (idx)
      REG_USE_TRANSFORM: return 64'(xform_on);
      REG_ROT_ROW_X:     return 64'(rot_rows[0]);
      REG_ROT_ROW_Y:     return 64'(rot_rows[1]);
      REG_ROT_ROW_Z:     return 64'(rot_rows[2]);
      REG_TRANSLATION:   return 64'(offsets);
      default:           return '0;
    endcase
  endfunction

  function automatic pixel_t make_pixel(int x, int y, int z, logic [31:0] bgra);
    pixel_t p;
    p.px = COORD_W'(x);
    p.py = COORD_W'(y);
    p.pz = COORD_W'(z);
    {p.blue, p.green, p.red, p.alpha} = bgra;
    return p;
  endfunction

  // Mostly full-range pixels, with a steady share of the cases the filter cares about.
  function automatic pixel_t random_pixel();
    pixel_t p;
    int     kind;
    kind = $urandom_range(15, 0);
    p = make_pixel($urandom, $urandom, $urandom, $urandom);
    case (kind)
      0: p.pz = '0;
      1: {p.blue, p.green, p.red, p.alpha} = '0;
      2: {p.blue, p.green, p.red} = '0;
      3: begin
        p.px = $urandom_range(1, 0) ? 16'h7FFF : 16'h8000;
        p.py = $urandom_range(1, 0) ? 16'h7FFF : 16'h8000;
        p.pz = $urandom_range(1, 0) ? 16'h7FFF : 16'h8000;
      end
      4: begin
        p.px = COORD_W'(int'($urandom_range(64, 0)) - 32);
        p.py = COORD_W'(int'($urandom_range(64, 0)) - 32);
        p.pz = COORD_W'(int'($urandom_range(64, 0)) - 32);
      end
      default: ;
    endcase
    return p;
  endfunction

  // Presents one pixel after a random gap and waits until the block takes it. Valid is
  // left high on return, so the next call either replaces the item or lowers valid.
  task automatic send_pixel(pixel_t p);
    point_t q;
    int     gap;
    gap = $urandom_range(send_idle_max, 0);
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.px    = p.px;
    in_ch.py    = p.py;
    in_ch.pz    = p.pz;
    in_ch.blue  = p.blue;
    in_ch.green = p.green;
    in_ch.red   = p.red;
    in_ch.alpha = p.alpha;
    in_ch.valid = 1'b1;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    items_sent++;
    if (predict_point(p, q)) owe_point(q);
    else pixels_dropped++;
  endtask

  // Lowers valid, waits for every owed point, then for the pipeline to empty of
  // dropped pixels too. Registers are only touched after this.
  task automatic drain();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (expected_points.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One APB transfer: a setup phase, then an access phase held until pready.
  task automatic apb_transfer(bit write, logic [REG_IDX_W-1:0] idx, logic [63:0] wdata,
                              output logic [63:0] rdata);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = write;
    paddr   = {idx, 3'b000};
    pwdata  = wdata;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    rdata = prdata;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [63:0] value);
    logic [63:0] unused;
    apb_transfer(1'b1, idx, value, unused);
    model_config(idx, value);
    config_writes++;
  endtask

  // Reads every register back and compares it with what our copy says it holds.
  task automatic verify_registers();
    logic [63:0] got;
    for (int i = 0; i <= REG_LAST; i++) begin
      apb_transfer(1'b0, REG_IDX_W'(i), '0, got);
      if (got !== reg_value(REG_IDX_W'(i)))
        report_mismatch($sformatf("register %0d read", i), got, reg_value(REG_IDX_W'(i)));
    end
  endtask

  // Result checker: every point that leaves the block is matched against the oldest
  // prediction. The receiver's next stall is drawn here, once per point taken.
  always @(posedge clk) begin
    point_t want;
    if (rst_n) begin
      if (in_ch.valid === 1'b1 && in_ch.ready !== 1'b1) input_stall_cycles++;
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        stall_left = $urandom_range(recv_idle_max, 0);
        if (expected_points.size() == 0) begin
          report_mismatch("point with none expected, qz", 64'(out_ch.qz), '0);
        end else begin
          want = expected_points.pop_front();
          points_checked++;
          if (out_ch.qx !== want.qx) report_mismatch("qx", 64'(out_ch.qx), 64'(want.qx));
          if (out_ch.qy !== want.qy) report_mismatch("qy", 64'(out_ch.qy), 64'(want.qy));
          if (out_ch.qz !== want.qz) report_mismatch("qz", 64'(out_ch.qz), 64'(want.qz));
          if (out_ch.out_blue !== want.blue)
            report_mismatch("out_blue", 64'(out_ch.out_blue), 64'(want.blue));
          if (out_ch.out_green !== want.green)
            report_mismatch("out_green", 64'(out_ch.out_green), 64'(want.green));
          if (out_ch.out_red !== want.red)
            report_mismatch("out_red", 64'(out_ch.out_red), 64'(want.red));
        end
      end
    end
  end

  // Receiver: a long hold-off takes priority over the per-point random stall; both are
  // counted down here, one cycle per falling edge.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ch.ready = 1'b0;
      hold_left--;
    end else if (stall_left > 0) begin
      out_ch.ready = 1'b0;
      stall_left--;
    end else begin
      out_ch.ready = 1'b1;
    end
  end

  // After reset the transform is off and the rotation is the identity.
  task automatic test_reset_values();
    verify_registers();
    send_pixel(make_pixel(100, -200, 300, 32'h11223344));
    send_pixel(make_pixel(-5, 7, -9, 32'h00000001));
  endtask

  // Bypass mode with coordinates at both ends of their range and single color bytes set.
  task automatic test_passthrough_extremes();
    send_idle_max = 0;
    recv_idle_max = 0;
    send_pixel(make_pixel(-32768, 32767, -1, 32'hFFFFFFFF));
    send_pixel(make_pixel(32767, -32768, 1, 32'h01000000));
    send_pixel(make_pixel(0, 0, -32768, 32'h00010000));
    send_pixel(make_pixel(-1, -1, 32767, 32'h00000100));
    send_pixel(make_pixel('h5555, 'hAAAA, 'h5555, 32'hAA55AA55));
    send_idle_max = MAX_IDLE;
    recv_idle_max = MAX_IDLE;
  endtask

  // Zero depth and a blank color are dropped; a pixel with only alpha set is kept.
  task automatic test_drop_cases();
    send_pixel(make_pixel(123, 456, 0, 32'hFFFFFFFF));
    send_pixel(make_pixel(123, 456, 789, 32'h00000000));
    send_pixel(make_pixel(0, 0, 0, 32'h00000000));
    send_pixel(make_pixel(-32768, -32768, 1, 32'h00000080));
  endtask

  // Transform mode with the extreme coefficients and offsets, wrap-around of large
  // results, and truncation toward zero deciding whether a small negative z survives.
  task automatic test_transform_directed();
    drain();
    write_reg(REG_USE_TRANSFORM, 64'd1);
    send_pixel(make_pixel(-32768, 32767, -32768, 32'h80808080));
    drain();
    write_reg(REG_ROT_ROW_X, {16'h0, {3{16'h8000}}});
    write_reg(REG_ROT_ROW_Y, {16'h0, {3{16'h7FFF}}});
    // z picks up px scaled by 2^-14, so small magnitudes round toward zero.
    write_reg(REG_ROT_ROW_Z, 64'h0001);
    write_reg(REG_TRANSLATION, {4'h0, 20'h00000, 20'h7FFFF, 20'h80000});
    verify_registers();
    send_pixel(make_pixel(-32768, -32768, -32768, 32'h01020304));
    send_pixel(make_pixel(-16383, 32767, 32767, 32'h05060708));
    send_pixel(make_pixel(-16384, 32767, 32767, 32'h090A0B0C));
    send_pixel(make_pixel(16383, -1, 1, 32'h0D0E0F10));
    drain();
    // With a z offset of one, a point that lands on -1 ends at zero depth.
    write_reg(REG_TRANSLATION, {4'h0, 20'h00001, 20'h00000, 20'h00000});
    send_pixel(make_pixel(-16384, 10, 10, 32'hFFFFFFFF));
    send_pixel(make_pixel(32767, 10, 10, 32'hFFFFFFFF));
  endtask

  // Bits above each register's width are cut off, and writes past the last register
  // are ignored.
  task automatic test_register_masking();
    drain();
    write_reg(REG_USE_TRANSFORM, 64'hFFFF_FFFF_FFFF_FFFE);
    write_reg(REG_ROT_ROW_X, '1);
    write_reg(REG_ROT_ROW_Y, '1);
    write_reg(REG_ROT_ROW_Z, '1);
    write_reg(REG_TRANSLATION, '1);
    for (int i = REG_LAST + 1; i < 2 ** REG_IDX_W; i++)
      write_reg(REG_IDX_W'(i), {$urandom, $urandom});
    verify_registers();
    write_reg(REG_USE_TRANSFORM, 64'hA5A5_0000_0000_0001);
    verify_registers();
    repeat (10) send_pixel(random_pixel());
  endtask

  task automatic random_config(cfg_kind_t kind);
    case (kind)
      CFG_MAX_COEF: begin
        write_reg(REG_USE_TRANSFORM, 64'd1);
        write_reg(REG_ROT_ROW_X, 64'({3{16'h7FFF}}));
        write_reg(REG_ROT_ROW_Y, 64'({3{16'h7FFF}}));
        write_reg(REG_ROT_ROW_Z, 64'({3{16'h7FFF}}));
        write_reg(REG_TRANSLATION, 64'({3{20'h7FFFF}}));
      end
      CFG_MIN_COEF: begin
        write_reg(REG_USE_TRANSFORM, 64'd1);
        write_reg(REG_ROT_ROW_X, 64'({3{16'h8000}}));
        write_reg(REG_ROT_ROW_Y, 64'({3{16'h8000}}));
        write_reg(REG_ROT_ROW_Z, 64'({3{16'h8000}}));
        write_reg(REG_TRANSLATION, 64'({3{20'h80000}}));
      end
      default: begin
        // Random values carry junk above each register's width on purpose.
        write_reg(REG_USE_TRANSFORM, {$urandom, 31'($urandom), kind != CFG_BYPASS});
        write_reg(REG_ROT_ROW_X, {$urandom, $urandom});
        write_reg(REG_ROT_ROW_Y, {$urandom, $urandom});
        write_reg(REG_ROT_ROW_Z, {$urandom, $urandom});
        write_reg(REG_TRANSLATION, {$urandom, $urandom});
      end
    endcase
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering items
  // back to back, so the pipeline fills and the input must stall.
  task automatic test_backpressure();
    drain();
    random_config(CFG_RANDOM);
    send_idle_max = 0;
    recv_idle_max = 0;
    @(posedge clk);
    hold_left = HOLD_CYCLES;
    repeat (48) send_pixel(random_pixel());
    send_idle_max = MAX_IDLE;
    recv_idle_max = MAX_IDLE;
  endtask

  // Bulk random traffic under a series of register settings, the extremes first, with
  // idling on both sides, on one side only, or off.
  task automatic test_random_configs();
    cfg_kind_t kind;
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      drain();
      case (phase)
        0:       kind = CFG_MAX_COEF;
        1:       kind = CFG_MIN_COEF;
        2:       kind = CFG_BYPASS;
        default: kind = CFG_RANDOM;
      endcase
      random_config(kind);
      verify_registers();
      send_idle_max = (phase % 3 == 1) ? 0 : MAX_IDLE;
      recv_idle_max = (phase % 3 == 2) ? 0 : MAX_IDLE;
      if (phase == NUM_PHASES - 1) begin
        send_idle_max = 0;
        recv_idle_max = 0;
      end
      repeat (PHASE_ITEMS) send_pixel(random_pixel());
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    in_ch.valid   = 1'b0;
    in_ch.px      = '0;
    in_ch.py      = '0;
    in_ch.pz      = '0;
    in_ch.blue    = '0;
    in_ch.green   = '0;
    in_ch.red     = '0;
    in_ch.alpha   = '0;
    out_ch.ready  = 1'b0;
    send_idle_max = MAX_IDLE;
    recv_idle_max = MAX_IDLE;
    stall_left    = 0;
    hold_left     = 0;
    // Our register copy starts at the reset values: off, identity rotation, no offset.
    xform_on      = 1'b0;
    rot_rows[0]   = ROT_RESET[0];
    rot_rows[1]   = ROT_RESET[1];
    rot_rows[2]   = ROT_RESET[2];
    offsets       = '0;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_values();
    test_passthrough_extremes();
    test_drop_cases();
    test_transform_directed();
    test_register_masking();
    test_backpressure();
    test_random_configs();
    drain();

    $display("Sent %0d pixels: %0d points checked, %0d filtered out, %0d register writes.",
             items_sent, points_checked, pixels_dropped, config_writes);
    $display("Input was held off by back-pressure for %0d cycles; %0d mismatches.",
             input_stall_cycles, fail_count);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/prt_pkg.sv
rtl/prt_in_if.sv
rtl/prt_out_if.sv
rtl/prt_row_mac.sv
rtl/point_rigid_transform_filter_core.sv
test/point_rigid_transform_filter_core_test.sv
